[sv/assert_macros.svh]
// assertion macros used by the priority queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define PQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define PQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[sv/pqms_pkg.sv]
// types, codes and compare function of the priority queue
package pqms_pkg;

    localparam int DEPTH_DEF = 256;
    localparam int REQ_W     = 2;
    localparam int VALUE_W   = 32;
    localparam int PRIO_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 9;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry item;
    } t_cell_ctl;

    // true when a is served strictly before b
    function automatic logic entry_better(input t_entry a, input t_entry b);
        logic prio_gt;
        logic prio_eq;
        logic value_lt;
        prio_gt  = a.prio > b.prio;
        prio_eq  = a.prio == b.prio;
        value_lt = $signed(a.value) < $signed(b.value);
        return prio_gt || (prio_eq && value_lt);
    endfunction

endpackage

[sv/pqms_req_if.sv]
// request channel interface of the priority queue
interface pqms_req_if;
    logic                              valid;
    logic                              ready;
    logic [pqms_pkg::REQ_W-1:0]        req_type;
    logic signed [pqms_pkg::VALUE_W-1:0] item_value;
    logic [pqms_pkg::PRIO_W-1:0]       item_priority;

    modport source (output valid, output req_type, output item_value,
                    output item_priority, input ready);
    modport sink (input valid, input req_type, input item_value,
                  input item_priority, output ready);
endinterface

[sv/pqms_rsp_if.sv]
// response channel interface of the priority queue
interface pqms_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [pqms_pkg::VALUE_W-1:0] out_value;
    logic [pqms_pkg::PRIO_W-1:0]         out_priority;
    logic [pqms_pkg::STATUS_W-1:0]       status;
    logic [pqms_pkg::FILL_W-1:0]         fill_level;

    modport source (output valid, output out_value, output out_priority,
                    output status, output fill_level, input ready);
    modport sink (input valid, input out_value, input out_priority,
                  input status, input fill_level, output ready);
endinterface

[sv/priority_queue_max_select.sv]
// priority queue top level: chain of sorted cells, count and response register
//
// Request channel i_req carries insert, peek or remove; response channel o_rsp
// returns one transaction per request with the best entry, a status and the
// fill level after the request. The best entry is the highest priority, and
// among equal priorities the smaller signed value.
// Entries sit in a row of DEPTH cells kept in sorted order: an insert lands
// in its place and shifts the worse entries one cell right, a remove shifts
// the whole row one cell left, so the best entry is always in the first cell.
// Every request finishes in the cycle it is accepted; its response is registered
// and shows in the next cycle. One request per cycle is taken as long as the
// response register is empty or being read in the same cycle, so throughput
// is one transaction per cycle; the row of cells does all work in parallel.
// Reset clears the entry count and the response valid; cell contents need no
// clearing since only cells below the count are ever compared or returned.
// When the receiver stalls, the response holds and i_req.ready stays low
// until it is taken. Insert when full reports full, peek or remove when empty
// reports empty, and the unused request code answers ok with no change.
module priority_queue_max_select #(
    parameter int DEPTH = pqms_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pqms_req_if.sink   i_req,
    pqms_rsp_if.source o_rsp
);
    import pqms_pkg::*;

`include "assert_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    t_entry    w_entry [DEPTH];
    logic      w_take  [DEPTH];
    logic      w_valid [DEPTH];
    t_cell_ctl w_ctl;

    logic                 w_accept;
    logic                 w_ready;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_value;
    logic [VALUE_W-1:0]   n_value;
    logic [PRIO_W-1:0]    r_prio;
    logic [PRIO_W-1:0]    n_prio;
    logic [STATUS_W-1:0]  r_status;
    logic [STATUS_W-1:0]  n_status;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_rsp_empty;
    logic                 w_rsp_zero;
    logic                 w_head_ok;

    assign w_ready  = !r_out_valid || o_rsp.ready;
    assign w_accept = i_req.valid && w_ready;
    assign w_full   = r_count == CW'(DEPTH);
    assign w_empty  = r_count == '0;

    always_comb begin
        w_ctl.item.value = i_req.item_value;
        w_ctl.item.prio  = i_req.item_priority;
        w_ctl.ins        = w_accept && (i_req.req_type == REQ_INSERT) && !w_full;
        w_ctl.rem        = w_accept && (i_req.req_type == REQ_REMOVE) && !w_empty;
    end

    always_comb begin
        n_count  = r_count;
        n_value  = '0;
        n_prio   = '0;
        n_status = ST_OK;
        unique case (i_req.req_type) inside
            REQ_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_PEEK, REQ_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_value = w_entry[0].value;
                    n_prio  = w_entry[0].prio;
                    if (i_req.req_type == REQ_REMOVE) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // cell row
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_valid[g] = CW'(g) < r_count;

        if (g == 0) begin : g_first
            if (DEPTH > 1) begin : g_more
                pqms_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (w_ctl),
                    .i_left_entry (w_ctl.item),
                    .i_left_take  (1'b0),
                    .i_right_entry(w_entry[1]),
                    .i_valid      (w_valid[0]),
                    .o_entry      (w_entry[0]),
                    .o_take       (w_take[0])
                );
            end else begin : g_one
                pqms_cell u_cell (
                    .i_clk        (i_clk),
                    .i_ctl        (w_ctl),
                    .i_left_entry (w_ctl.item),
                    .i_left_take  (1'b0),
                    .i_right_entry('0),
                    .i_valid      (w_valid[0]),
                    .o_entry      (w_entry[0]),
                    .o_take       (w_take[0])
                );
            end
        end else if (g == DEPTH - 1) begin : g_last
            pqms_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_left_entry (w_entry[g-1]),
                .i_left_take  (w_take[g-1]),
                .i_right_entry('0),
                .i_valid      (w_valid[g]),
                .o_entry      (w_entry[g]),
                .o_take       (w_take[g])
            );
        end else begin : g_mid
            pqms_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_left_entry (w_entry[g-1]),
                .i_left_take  (w_take[g-1]),
                .i_right_entry(w_entry[g+1]),
                .i_valid      (w_valid[g]),
                .o_entry      (w_entry[g]),
                .o_take       (w_take[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_value  <= n_value;
            r_prio   <= n_prio;
            r_status <= n_status;
        end
    end

    assign i_req.ready        = w_ready;
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.out_value    = r_value;
    assign o_rsp.out_priority = r_prio;
    assign o_rsp.status       = r_status;
    assign o_rsp.fill_level   = FILL_W'(r_count);

    assign w_rsp_empty = r_out_valid && (r_status == ST_EMPTY);
    assign w_rsp_zero  = (r_value == '0) && (r_prio == '0) && (r_count == '0);
    assign w_head_ok   = !entry_better(w_entry[DEPTH > 1 ? 1 : 0], w_entry[0]);

    `PQ_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))
    `PQ_ASSERT_NXT(a_insert_count, i_clk, i_rst_n, w_ctl.ins, r_count == CW'($past(r_count) + 1'b1))
    `PQ_ASSERT_IMP(a_empty_resp, i_clk, i_rst_n, w_rsp_empty, w_rsp_zero)
    `PQ_ASSERT_IMP(a_head_sorted, i_clk, i_rst_n, (DEPTH > 1) && (r_count > CW'(1)), w_head_ok)

endmodule

[sv/pqms_cell.sv]
// one cell of the sorted shift chain
module pqms_cell (
    input  logic               i_clk,
    input  pqms_pkg::t_cell_ctl i_ctl,
    input  pqms_pkg::t_entry   i_left_entry,
    input  logic               i_left_take,
    input  pqms_pkg::t_entry   i_right_entry,
    input  logic               i_valid,
    output pqms_pkg::t_entry   o_entry,
    output logic               o_take
);
    import pqms_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        o_take  = !i_valid || entry_better(i_ctl.item, r_entry);
        n_entry = r_entry;
        if (i_ctl.ins && o_take) begin
            n_entry = i_left_take ? i_left_entry : i_ctl.item;
        end else if (i_ctl.rem) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
